### src/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types, code tree node codes and the tree step function for the
// prefix code triplet decoder.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int LenWidth  = 16;
  localparam int GrpWidth  = 3;
  localparam int CntWidth  = 2;
  localparam int NodeWidth = 3;

  localparam logic [CntWidth-1:0] CntCode = 2'd3;
  localparam logic [CntWidth-1:0] CntRaw  = 2'd1;

  // code tree nodes
  localparam logic [NodeWidth-1:0] NODE_ROOT = 3'd0;
  localparam logic [NodeWidth-1:0] NODE_0    = 3'd1;
  localparam logic [NodeWidth-1:0] NODE_01   = 3'd2;
  localparam logic [NodeWidth-1:0] NODE_1    = 3'd3;
  localparam logic [NodeWidth-1:0] NODE_10   = 3'd4;
  localparam logic [NodeWidth-1:0] NODE_11   = 3'd5;
  localparam logic [NodeWidth-1:0] NODE_111  = 3'd6;

  // register indexes
  localparam logic [0:0] REG_OUTPUT_LENGTH = 1'b0;

  // outcome of one tree step
  typedef struct packed {
    logic                 done;
    logic [GrpWidth-1:0]  grp;
    logic [NodeWidth-1:0] node_next;
  } tree_step_t;

  // one result transfer
  typedef struct packed {
    logic [GrpWidth-1:0] grp;
    logic [CntWidth-1:0] cnt;
    logic                fin;
  } out_item_t;

  // result of the core toward the output queue
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  function automatic tree_step_t tree_step(input logic [NodeWidth-1:0] node,
                                           input logic bit_in);
    tree_step_t s;
    s.done      = 1'b0;
    s.grp       = '0;
    s.node_next = NODE_ROOT;
    unique case (node)
      NODE_ROOT: s.node_next = bit_in ? NODE_1 : NODE_0;
      NODE_0: begin
        if (bit_in) begin
          s.node_next = NODE_01;
        end else begin
          s.done = 1'b1;
          s.grp  = 3'd0;
        end
      end
      NODE_01: begin
        s.done = 1'b1;
        s.grp  = bit_in ? 3'd2 : 3'd1;
      end
      NODE_1:  s.node_next = bit_in ? NODE_11 : NODE_10;
      NODE_10: begin
        s.done = 1'b1;
        s.grp  = bit_in ? 3'd6 : 3'd4;
      end
      NODE_11: begin
        if (bit_in) begin
          s.node_next = NODE_111;
        end else begin
          s.done = 1'b1;
          s.grp  = 3'd3;
        end
      end
      NODE_111: begin
        s.done = 1'b1;
        s.grp  = bit_in ? 3'd7 : 3'd5;
      end
      default: s.node_next = NODE_ROOT;
    endcase
    return s;
  endfunction

endpackage

### src/pcd_tree.sv
// ----------------------------------------------------------------------------
// pcd_tree
// One step of the code tree walk: next node, code end and decoded group.
// ----------------------------------------------------------------------------
module pcd_tree
  import pcd_pkg::*;
(
  input  logic [NodeWidth-1:0] node,
  input  logic                 bit_in,
  output tree_step_t           step
);

  // tree walk for the incoming bit
  always_comb begin
    step = tree_step(node, bit_in);
  end

endmodule

### src/pcd_core.sv
// ----------------------------------------------------------------------------
// pcd_core
// Length register, tree position and produced bit count; forms the result
// of each accepted coded bit.
// ----------------------------------------------------------------------------
module pcd_core
  import pcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                bit_in,
  input  logic                cfg_wr,
  input  logic [LenWidth-1:0] cfg_len,
  output logic [LenWidth-1:0] output_length,
  output result_t             res
);

  logic [NodeWidth-1:0] tree_node;
  logic [NodeWidth-1:0] tree_node_next;
  logic [LenWidth-1:0]  produced_count;
  logic [LenWidth-1:0]  produced_count_next;
  tree_step_t           step;
  logic                 code_phase;
  logic [LenWidth:0]    sum;

  pcd_tree u_tree (
    .node   (tree_node),
    .bit_in (bit_in),
    .step   (step)
  );

  // produced count stays a multiple of three while codes are decoded,
  // so a whole group still fits when count plus three is within the length
  assign code_phase = ({1'b0, produced_count} + (LenWidth+1)'(3))
                      <= {1'b0, output_length};

  // result forming and state update
  always_comb begin
    res                 = '0;
    tree_node_next      = tree_node;
    produced_count_next = produced_count;
    sum                 = '0;
    if (accept && (output_length != '0)) begin
      if (code_phase) begin
        tree_node_next = step.node_next;
        res.valid      = step.done;
        res.item.grp   = step.grp;
        res.item.cnt   = CntCode;
      end else begin
        res.valid      = 1'b1;
        res.item.grp   = {2'b00, bit_in};
        res.item.cnt   = CntRaw;
      end
      if (res.valid) begin
        sum                 = {1'b0, produced_count} + (LenWidth+1)'(res.item.cnt);
        res.item.fin        = sum >= {1'b0, output_length};
        produced_count_next = sum[LenWidth-1:0];
        if (res.item.fin) begin
          tree_node_next      = NODE_ROOT;
          produced_count_next = '0;
        end
      end
    end
  end

  // state registers; a length write starts a new block
  always_ff @(posedge clk) begin
    if (rst) begin
      output_length  <= '0;
      tree_node      <= NODE_ROOT;
      produced_count <= '0;
    end else if (cfg_wr) begin
      output_length  <= cfg_len;
      tree_node      <= NODE_ROOT;
      produced_count <= '0;
    end else begin
      tree_node      <= tree_node_next;
      produced_count <= produced_count_next;
    end
  end

  // block ends clear the count
  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.item.fin) |=> (produced_count == '0 && tree_node == NODE_ROOT))
    else $error("count not cleared after final result");

  // count never passes the length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    produced_count <= output_length)
    else $error("produced count above output length");

  // raw tail bits only come at the top of the tree
  a_raw_at_root: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.item.cnt == CntRaw) |-> tree_node == NODE_ROOT)
    else $error("raw bit taken inside a code");

endmodule

### src/pcd_outq.sv
// ----------------------------------------------------------------------------
// pcd_outq
// Result register with a skid stage, so coded bits keep flowing while a
// result waits to be taken.
// ----------------------------------------------------------------------------
module pcd_outq
  import pcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  result_t   res,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      skid_valid;
  out_item_t skid_item;
  logic      pop;

  assign space = !skid_valid;
  assign pop   = out_valid && out_ready;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res.valid;
      end
    end else if (res.valid) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (res.valid) begin
        out_item <= res.item;
      end
    end else if (res.valid) begin
      if (out_valid) begin
        skid_item <= res.item;
      end else begin
        out_item <= res.item;
      end
    end
  end

  // skid only fills behind a held result
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result with output empty");

  // no result arrives while the skid is full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !res.valid)
    else $error("result lost to full queue");

  // a stalled full queue stays full
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_ready) |=> (skid_valid && out_valid))
    else $error("queue dropped a result while stalled");

endmodule

### src/prefix_code_triplet_decoder.sv
// ----------------------------------------------------------------------------
// prefix_code_triplet_decoder
// Serial prefix code decoder: one coded bit per transfer, 3-bit groups and
// raw tail bits out, with an APB-style length register.
// ----------------------------------------------------------------------------
// Timing: the tree walk and count update act together on the accepted coded bit; the result
//   is registered in the output register, or in the skid stage while the output is held.
// Throughput: 1 coded bit per cycle; a result that meets a stalled output waits
//   in the skid stage, and in_ready is low until the output transfer that frees it.
// Reset: synchronous rst clears output_length to 0 (bits ignored), the tree
//   position to the root, the produced count and both output stages.
module prefix_code_triplet_decoder
  import pcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // coded bit channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                coded_bit,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [GrpWidth-1:0] decoded_bits,
  output logic [CntWidth-1:0] bit_count,
  output logic                final_flag,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic                accept;
  logic                cfg_wr;
  logic [0:0]          reg_index;
  logic [LenWidth-1:0] output_length;
  result_t             res;
  out_item_t           out_item;

  // register access
  assign pready    = 1'b1;
  assign reg_index = paddr[2:2];
  assign cfg_wr    = psel && penable && pwrite && (reg_index == REG_OUTPUT_LENGTH);

  always_comb begin
    unique case (reg_index)
      REG_OUTPUT_LENGTH: prdata = {{(32-LenWidth){1'b0}}, output_length};
      default:           prdata = '0;
    endcase
  end

  // coded bit transfer
  assign accept = in_valid && in_ready;

  pcd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .bit_in        (coded_bit),
    .cfg_wr        (cfg_wr),
    .cfg_len       (pwdata[LenWidth-1:0]),
    .output_length (output_length),
    .res           (res)
  );

  pcd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign decoded_bits = out_item.grp;
  assign bit_count    = out_item.cnt;
  assign final_flag   = out_item.fin;

endmodule
